// ----- rtl/hexpp_pkg.sv -----
// Shared types, character codes and the hex digit decoder for the pattern parser.
package hexpp_pkg;

    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [7:0] CHAR_PIPE    = 8'h7C;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    typedef enum logic [1:0] {
        MODE_LITERAL  = 2'd0,
        MODE_FIRST    = 2'd1,
        MODE_SECOND   = 2'd2,
        MODE_FIRST_SP = 2'd3
    } parse_mode_t;

    typedef struct packed {
        parse_mode_t        parse_mode;
        logic [3:0]         high_nibble;
        logic               error_seen;
        logic [COUNT_W-1:0] decoded_count;
    } parse_state_t;

    typedef struct packed {
        logic               byte_valid;
        logic [7:0]         out_byte;
        logic               line_done;
        logic               parse_error;
        logic [COUNT_W-1:0] pattern_length;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    localparam parse_state_t STATE_RESET = '{
        parse_mode:    MODE_LITERAL,
        high_nibble:   4'd0,
        error_seen:    1'b0,
        decoded_count: '0
    };

    function automatic hex_digit_t hex_decode(logic [7:0] c);
        hex_digit_t d;
        logic [7:0] v;
        d = '{is_hex: 1'b0, value: 4'd0};
        v = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
            d = '{is_hex: 1'b1, value: v[3:0]};
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            v = c - CHAR_LOWER_A + HEX_LETTER_BASE;
            d = '{is_hex: 1'b1, value: v[3:0]};
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            v = c - CHAR_UPPER_A + HEX_LETTER_BASE;
            d = '{is_hex: 1'b1, value: v[3:0]};
        end
        return d;
    endfunction

endpackage

// ----- rtl/hexpp_if.sv -----
// Valid/ready channel interfaces for raw line bytes and parsed pattern results.
interface hexpp_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_line;

    modport source (output valid, output in_byte, output end_of_line, input ready);
    modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface hexpp_pat_if;
    logic                           valid;
    logic                           ready;
    logic                           byte_valid;
    logic [7:0]                     out_byte;
    logic                           line_done;
    logic                           parse_error;
    logic [hexpp_pkg::COUNT_W-1:0]  pattern_length;

    modport source (output valid, output byte_valid, output out_byte, output line_done,
                    output parse_error, output pattern_length, input ready);
    modport sink   (input valid, input byte_valid, input out_byte, input line_done,
                    input parse_error, input pattern_length, output ready);
endinterface

// ----- rtl/hex_escaped_pattern_parser.sv -----
// Pipe-delimited hex escape pattern parser, one raw byte per beat.
// An accepted raw beat's result is registered and offered the next cycle.
// One byte per cycle unless stalled; the state update is the only loop.
// raw.ready stays high while the result register is empty or being taken.
// Reset clears the parser state, the line byte counter and the result valid.
module hex_escaped_pattern_parser #(
    parameter int MAX_LINE_BYTES = 4096
) (
    input logic         clk,
    input logic         rst_n,
    hexpp_raw_if.sink   raw,
    hexpp_pat_if.source pattern
);
    import hexpp_pkg::*;

    localparam int LB_W = $clog2(MAX_LINE_BYTES + 2);

    parse_state_t    state_reg;
    parse_state_t    state_next;
    logic [LB_W-1:0] line_bytes_reg;
    logic [LB_W-1:0] line_bytes_next;
    result_t         step_result;
    result_t         result_reg;
    logic            out_valid_reg;
    logic            accept;

    assign raw.ready = !out_valid_reg || pattern.ready;
    assign accept    = raw.valid && raw.ready;

    hexpp_step #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .LB_W           (LB_W)
    ) u_step (
        .in_byte         (raw.in_byte),
        .end_of_line     (raw.end_of_line),
        .state           (state_reg),
        .line_bytes      (line_bytes_reg),
        .state_next      (state_next),
        .line_bytes_next (line_bytes_next),
        .result          (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_RESET;
            line_bytes_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else
        begin
            if (accept)
            begin
                state_reg      <= state_next;
                line_bytes_reg <= line_bytes_next;
            end
            // hold the result beat until taken
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end else if (pattern.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= step_result;
        end
    end

    assign pattern.valid          = out_valid_reg;
    assign pattern.byte_valid     = result_reg.byte_valid;
    assign pattern.out_byte       = result_reg.out_byte;
    assign pattern.line_done      = result_reg.line_done;
    assign pattern.parse_error    = result_reg.parse_error;
    assign pattern.pattern_length = result_reg.pattern_length;

endmodule

// ----- rtl/hexpp_step.sv -----
// Per-byte parse step: next parser state and the result for one raw byte.
module hexpp_step #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int LB_W           = 13
) (
    input  logic [7:0]              in_byte,
    input  logic                    end_of_line,
    input  hexpp_pkg::parse_state_t state,
    input  logic [LB_W-1:0]         line_bytes,
    output hexpp_pkg::parse_state_t state_next,
    output logic [LB_W-1:0]         line_bytes_next,
    output hexpp_pkg::result_t      result
);
    import hexpp_pkg::*;

    localparam logic [LB_W-1:0] LB_MAX = LB_W'(MAX_LINE_BYTES);

    hex_digit_t         digit;
    logic [LB_W-1:0]    lb_inc;
    logic               err_in;
    parse_mode_t        mode_next;
    logic [3:0]         nibble_next;
    logic               syntax_err;
    logic               emit_raw;
    logic               emit;
    logic [7:0]         emit_byte;
    logic               count_full;
    logic [COUNT_W-1:0] count_next;
    logic               err_final;

    assign digit  = hex_decode(in_byte);
    // saturate one past the limit
    assign lb_inc = (line_bytes <= LB_MAX) ? line_bytes + 1'b1 : line_bytes;
    assign err_in = state.error_seen | (lb_inc > LB_MAX);

    // next mode
    always_comb
    begin
        mode_next   = state.parse_mode;
        nibble_next = state.high_nibble;
        syntax_err  = 1'b0;
        if (!err_in)
        begin
            unique case (state.parse_mode)
                MODE_LITERAL:
                begin
                    if (in_byte == CHAR_PIPE)
                    begin
                        mode_next = MODE_FIRST;
                    end
                end
                MODE_FIRST, MODE_FIRST_SP:
                begin
                    if (in_byte == CHAR_SPACE)
                    begin
                        mode_next = MODE_FIRST_SP;
                    end else if (in_byte == CHAR_PIPE && state.parse_mode == MODE_FIRST)
                    begin
                        mode_next = MODE_LITERAL;
                    end else if (digit.is_hex)
                    begin
                        nibble_next = digit.value;
                        mode_next   = MODE_SECOND;
                    end else
                    begin
                        syntax_err = 1'b1;
                    end
                end
                MODE_SECOND:
                begin
                    if (in_byte == CHAR_SPACE)
                    begin
                        mode_next = MODE_SECOND;
                    end else if (digit.is_hex)
                    begin
                        mode_next = MODE_FIRST;
                    end else
                    begin
                        syntax_err = 1'b1;
                    end
                end
                default:
                begin
                    syntax_err = 1'b1;
                end
            endcase
        end
    end

    // emitted byte, count and line-end report
    always_comb
    begin
        emit_raw  = !err_in &&
                    ((state.parse_mode == MODE_LITERAL && in_byte != CHAR_PIPE) ||
                     (state.parse_mode == MODE_SECOND && digit.is_hex));
        emit_byte = (state.parse_mode == MODE_LITERAL) ? in_byte
                                                       : {state.high_nibble, digit.value};
        count_full = (state.decoded_count == COUNT_MAX);
        emit       = emit_raw && !count_full;
        count_next = emit ? state.decoded_count + 1'b1 : state.decoded_count;
        err_final  = err_in || syntax_err || (emit_raw && count_full) ||
                     (end_of_line && mode_next != MODE_LITERAL);

        result.byte_valid     = emit;
        result.out_byte       = emit ? emit_byte : 8'd0;
        result.line_done      = end_of_line;
        result.parse_error    = end_of_line && err_final;
        result.pattern_length = (end_of_line && !err_final) ? count_next : '0;
    end

    // back to reset values after the last byte of a line
    always_comb
    begin
        if (end_of_line)
        begin
            state_next      = STATE_RESET;
            line_bytes_next = '0;
        end else
        begin
            state_next.parse_mode    = mode_next;
            state_next.high_nibble   = nibble_next;
            state_next.error_seen    = err_final;
            state_next.decoded_count = count_next;
            line_bytes_next          = lb_inc;
        end
    end

endmodule
